@@ hw/rtl/svge_pkg.sv @@
// Shared types, codes and arithmetic helpers for the state vector gate engine.
`timescale 1ns / 1ps
`default_nettype none
package svge_pkg;
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_GATE = 2'd2;

    localparam logic [1:0] REPLY_LOAD = 2'd0;
    localparam logic [1:0] REPLY_READ = 2'd1;
    localparam logic [1:0] REPLY_GATE = 2'd2;

    localparam logic [3:0] G_H    = 4'd0;
    localparam logic [3:0] G_X    = 4'd1;
    localparam logic [3:0] G_Y    = 4'd2;
    localparam logic [3:0] G_Z    = 4'd3;
    localparam logic [3:0] G_S    = 4'd4;
    localparam logic [3:0] G_T    = 4'd5;
    localparam logic [3:0] G_CNOT = 4'd6;
    localparam logic [3:0] G_PH   = 4'd7;
    localparam logic [3:0] G_SWAP = 4'd8;
    localparam logic [3:0] G_CZ   = 4'd9;
    localparam logic [3:0] G_TOF  = 4'd10;

    localparam logic signed [15:0] INV_SQRT2 = 16'sd23170;

    typedef struct packed {
        logic [1:0]         mode;
        logic               gate_ok;
        logic [3:0]         kind;
        logic [3:0]         tq;
        logic [3:0]         cq;
        logic [3:0]         c2q;
        logic [9:0]         idx;
        logic signed [15:0] lre;
        logic signed [15:0] lim;
        logic signed [15:0] pc;
        logic signed [15:0] ps;
        logic [10:0]        rstart;
        logic [10:0]        rend;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

    function automatic logic signed [15:0] sat16(input logic signed [33:0] x);
        logic signed [15:0] r;
        if (x > 34'sd32767)
            r = 16'sh7fff;
        else if (x < -34'sd32768)
            r = 16'sh8000;
        else
            r = x[15:0];
        return r;
    endfunction

    function automatic logic signed [15:0] rnd15(input logic signed [33:0] p);
        logic signed [33:0] q;
        q = p + 34'sd16384;
        return sat16(q >>> 15);
    endfunction

    function automatic logic signed [15:0] neg16(input logic signed [15:0] x);
        return (x == 16'sh8000) ? 16'sh7fff : -x;
    endfunction
endpackage
`default_nettype wire

@@ hw/rtl/svge_front.sv @@
// Front end: accepts commands, checks gate operands and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module svge_front #(
    parameter int QUBITS = 10
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire svge_pkg::cmd_t in_cmd,
    output svge_pkg::cmd_t     out_cmd,
    output svge_pkg::hs_t      q_hs_o,
    input  wire logic          q_pop
);
    import svge_pkg::*;

    cmd_t   q_reg [2];
    logic   rd_ptr_reg, rd_ptr_next, wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic   push, need_c;
    cmd_t   dec;

    always_comb
    begin
        need_c = (in_cmd.kind == G_CNOT) || (in_cmd.kind == G_SWAP)
              || (in_cmd.kind == G_CZ) || (in_cmd.kind == G_TOF);
        dec = in_cmd;
        dec.gate_ok = (in_cmd.kind <= G_TOF) && (32'(in_cmd.tq) < QUBITS)
                   && (!need_c || (32'(in_cmd.cq) < QUBITS))
                   && ((in_cmd.kind != G_TOF) || (32'(in_cmd.c2q) < QUBITS));
    end

    assign busy = (cnt_reg == 2'd2);
    assign push = start && !busy;
    assign out_cmd = q_reg[rd_ptr_reg];
    assign q_hs_o.valid = (cnt_reg != 2'd0);
    assign q_hs_o.ready = !busy;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/svge_back.sv @@
// Back end: amplitude memory and the sequencer that runs loads, reads and gate sweeps.
`timescale 1ns / 1ps
`default_nettype none
module svge_back #(
    parameter int QUBITS = 10
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire svge_pkg::cmd_t in_cmd,
    input  wire svge_pkg::hs_t  q_hs_i,
    output logic                q_pop,
    output logic                done,
    output logic [1:0]          reply_kind,
    output logic signed [15:0]  read_real,
    output logic signed [15:0]  read_imag
);
    import svge_pkg::*;

    localparam int AW = QUBITS;
    localparam int IW = ((QUBITS > 11) ? QUBITS : 11) + 1;
    localparam logic [IW-1:0] AMP_COUNT = IW'(1) << QUBITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DISP  = 3'd1;
    localparam logic [2:0] ST_RWAIT = 3'd2;
    localparam logic [2:0] ST_VISIT = 3'd3;
    localparam logic [2:0] ST_RDB   = 3'd4;
    localparam logic [2:0] ST_CALC  = 3'd5;
    localparam logic [2:0] ST_WRA   = 3'd6;
    localparam logic [2:0] ST_WRB   = 3'd7;

    logic [31:0]   mem [2**AW];
    logic [31:0]   rd_data_reg;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [31:0]   wr_data;

    logic [2:0]    state_reg, state_next;
    cmd_t          cur_reg, cur_next;
    logic [IW-1:0] i_reg, i_next, end_eff;
    logic [AW-1:0] pa_reg, pa_next, pb_reg, pb_next;
    logic          pair_reg, pair_next;
    logic [31:0]   a_reg, a_next, na_reg, na_next, nb_reg, nb_next;
    logic          done_next;
    logic [1:0]    kind_next;
    logic [31:0]   rdat_next;

    logic [AW-1:0] ii, tb, cb, c2b, jt, ks;
    logic          act, pair;
    logic signed [15:0] ar, ai, br, bi, cc, cs;
    logic signed [33:0] s0r, s0i, d0r, d0i, pre, pim;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        ii  = i_reg[AW-1:0];
        tb  = AW'(1) << cur_reg.tq;
        cb  = AW'(1) << cur_reg.cq;
        c2b = AW'(1) << cur_reg.c2q;
        jt  = ii | tb;
        ks  = ii ^ tb ^ cb;
        end_eff = (IW'(cur_reg.rend) > AMP_COUNT) ? AMP_COUNT : IW'(cur_reg.rend);
        act = 1'b0;
        pair = 1'b0;
        case (cur_reg.kind)
            G_H, G_X, G_Y:
            begin
                act = (ii & tb) == '0;
                pair = 1'b1;
            end
            G_Z, G_S, G_T, G_PH: act = (ii & tb) != '0;
            G_CNOT:
            begin
                act = ((ii & cb) != '0) && ((ii & tb) == '0);
                pair = 1'b1;
            end
            G_SWAP:
            begin
                act = (((ii & tb) != '0) != ((ii & cb) != '0)) && (ii < ks);
                pair = 1'b1;
            end
            G_CZ: act = (ii & (tb | cb)) == (tb | cb);
            G_TOF:
            begin
                act = ((ii & (cb | c2b)) == (cb | c2b)) && ((ii & tb) == '0);
                pair = 1'b1;
            end
            default: act = 1'b0;
        endcase
    end

    always_comb
    begin
        ar = a_reg[31:16];
        ai = a_reg[15:0];
        br = rd_data_reg[31:16];
        bi = rd_data_reg[15:0];
        cc = (cur_reg.kind == G_PH) ? cur_reg.pc : INV_SQRT2;
        cs = (cur_reg.kind == G_PH) ? cur_reg.ps : INV_SQRT2;
        s0r = (34'(ar) + 34'(br)) * 34'(INV_SQRT2);
        s0i = (34'(ai) + 34'(bi)) * 34'(INV_SQRT2);
        d0r = (34'(ar) - 34'(br)) * 34'(INV_SQRT2);
        d0i = (34'(ai) - 34'(bi)) * 34'(INV_SQRT2);
        pre = 34'(ar) * 34'(cc) - 34'(ai) * 34'(cs);
        pim = 34'(ar) * 34'(cs) + 34'(ai) * 34'(cc);
    end

    always_comb
    begin
        state_next = state_reg;
        cur_next = cur_reg;
        i_next = i_reg;
        pa_next = pa_reg;
        pb_next = pb_reg;
        pair_next = pair_reg;
        a_next = a_reg;
        na_next = na_reg;
        nb_next = nb_reg;
        done_next = 1'b0;
        kind_next = REPLY_LOAD;
        rdat_next = '0;
        q_pop = 1'b0;
        rd_en = 1'b0;
        rd_addr = ii;
        wr_en = 1'b0;
        wr_addr = pa_reg;
        wr_data = na_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_hs_i.valid)
                begin
                    q_pop = 1'b1;
                    cur_next = in_cmd;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                case (cur_reg.mode)
                    MODE_LOAD:
                    begin
                        wr_en = 1'b1;
                        wr_addr = AW'(cur_reg.idx);
                        wr_data = {cur_reg.lre, cur_reg.lim};
                        done_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    MODE_READ:
                    begin
                        rd_en = 1'b1;
                        rd_addr = AW'(cur_reg.idx);
                        state_next = ST_RWAIT;
                    end
                    MODE_GATE:
                    begin
                        if (cur_reg.gate_ok)
                        begin
                            i_next = IW'(cur_reg.rstart);
                            state_next = ST_VISIT;
                        end
                        else
                        begin
                            done_next = 1'b1;
                            kind_next = REPLY_GATE;
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        done_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_RWAIT:
            begin
                done_next = 1'b1;
                kind_next = REPLY_READ;
                rdat_next = rd_data_reg;
                state_next = ST_IDLE;
            end
            ST_VISIT:
            begin
                if (i_reg >= end_eff)
                begin
                    done_next = 1'b1;
                    kind_next = REPLY_GATE;
                    state_next = ST_IDLE;
                end
                else if (act)
                begin
                    rd_en = 1'b1;
                    rd_addr = ii;
                    pa_next = ii;
                    pb_next = (cur_reg.kind == G_SWAP) ? ks : jt;
                    pair_next = pair;
                    state_next = ST_RDB;
                end
                else
                    i_next = i_reg + IW'(1);
            end
            ST_RDB:
            begin
                a_next = rd_data_reg;
                if (pair_reg)
                begin
                    rd_en = 1'b1;
                    rd_addr = pb_reg;
                end
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                case (cur_reg.kind)
                    G_H:
                    begin
                        na_next = {rnd15(s0r), rnd15(s0i)};
                        nb_next = {rnd15(d0r), rnd15(d0i)};
                    end
                    G_Y:
                    begin
                        na_next = {bi, neg16(br)};
                        nb_next = {neg16(ai), ar};
                    end
                    G_Z, G_CZ: na_next = {neg16(ar), neg16(ai)};
                    G_S: na_next = {neg16(ai), ar};
                    G_T, G_PH: na_next = {rnd15(pre), rnd15(pim)};
                    default:
                    begin
                        na_next = rd_data_reg;
                        nb_next = a_reg;
                    end
                endcase
                state_next = ST_WRA;
            end
            ST_WRA:
            begin
                wr_en = 1'b1;
                if (pair_reg)
                    state_next = ST_WRB;
                else
                begin
                    i_next = i_reg + IW'(1);
                    state_next = ST_VISIT;
                end
            end
            ST_WRB:
            begin
                wr_en = 1'b1;
                wr_addr = pb_reg;
                wr_data = nb_reg;
                i_next = i_reg + IW'(1);
                state_next = ST_VISIT;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        i_reg <= i_next;
        pa_reg <= pa_next;
        pb_reg <= pb_next;
        pair_reg <= pair_next;
        a_reg <= a_next;
        na_reg <= na_next;
        nb_reg <= nb_next;
        reply_kind <= kind_next;
        read_real <= rdat_next[31:16];
        read_imag <= rdat_next[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done <= done_next;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/state_vector_gate_engine.sv @@
// Top level of the state vector gate engine.
// Usage:
//   Commands enter on start with the item fields; an item is taken at a clock
//   edge where start is high and busy is low. busy rises when the two-entry
//   command queue is full.
//   Each item yields one reply: done pulses for one cycle with reply_kind and,
//   for a read, read_real/read_imag (zero otherwise). The receiver cannot stall.
//   A load is written and a rejected gate replies at dispatch; a read fetches
//   its amplitude at dispatch and replies from the registered memory output.
//   A gate sweep visits each index of the range in turn: a skipped index only
//   advances; an active index reads its amplitude and, for pair gates, the
//   partner, then computes and writes the new amplitude and, for pairs, the partner.
//   Reset empties the queue and returns the sequencer to idle. Amplitude
//   memory is not cleared; entries must be loaded before they are used.
`timescale 1ns / 1ps
`default_nettype none
module state_vector_gate_engine #(
    parameter int QUBITS = 10
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         mode,
    input  wire logic [3:0]         gate_kind,
    input  wire logic [3:0]         target_qubit,
    input  wire logic [3:0]         control_qubit,
    input  wire logic [3:0]         second_control,
    input  wire logic [9:0]         amp_index,
    input  wire logic signed [15:0] load_real,
    input  wire logic signed [15:0] load_imag,
    input  wire logic signed [15:0] phase_cos,
    input  wire logic signed [15:0] phase_sin,
    input  wire logic [10:0]        range_start,
    input  wire logic [10:0]        range_end,
    output logic                    done,
    output logic [1:0]              reply_kind,
    output logic signed [15:0]      read_real,
    output logic signed [15:0]      read_imag
);
    import svge_pkg::*;

    cmd_t in_cmd, q_cmd;
    hs_t  q_hs;
    logic q_pop;

    always_comb
    begin
        in_cmd.mode = mode;
        in_cmd.gate_ok = 1'b0;
        in_cmd.kind = gate_kind;
        in_cmd.tq = target_qubit;
        in_cmd.cq = control_qubit;
        in_cmd.c2q = second_control;
        in_cmd.idx = amp_index;
        in_cmd.lre = load_real;
        in_cmd.lim = load_imag;
        in_cmd.pc = phase_cos;
        in_cmd.ps = phase_sin;
        in_cmd.rstart = range_start;
        in_cmd.rend = range_end;
    end

    svge_front #(.QUBITS(QUBITS)) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .in_cmd(in_cmd),
        .out_cmd(q_cmd),
        .q_hs_o(q_hs),
        .q_pop(q_pop)
    );

    svge_back #(.QUBITS(QUBITS)) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .in_cmd(q_cmd),
        .q_hs_i(q_hs),
        .q_pop(q_pop),
        .done(done),
        .reply_kind(reply_kind),
        .read_real(read_real),
        .read_imag(read_imag)
    );
endmodule
`default_nettype wire

@@ hw/rtl/svge_checker.sv @@
// Port-level checker for the state vector gate engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module svge_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               busy,
    input wire logic               done,
    input wire logic [1:0]         reply_kind,
    input wire logic signed [15:0] read_real,
    input wire logic signed [15:0] read_imag
);
    import svge_pkg::*;

    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        done && (reply_kind != REPLY_READ) |-> (read_real == 16'sd0) && (read_imag == 16'sd0))
        else $error("non-read reply carries data");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (reply_kind == REPLY_LOAD) || (reply_kind == REPLY_READ)
              || (reply_kind == REPLY_GATE))
        else $error("illegal reply kind");

    a_reset_quiet: assert property (@(posedge clk)
        $past(!rst_n) |-> !done && !busy)
        else $error("activity right after reset");
endmodule

bind state_vector_gate_engine svge_checker u_svge_checker (
    .clk(clk),
    .rst_n(rst_n),
    .busy(busy),
    .done(done),
    .reply_kind(reply_kind),
    .read_real(read_real),
    .read_imag(read_imag)
);
`default_nettype wire
